// ===== rtl/core/hkt_pkg.sv =====
// Package for the held key table: sizes, payload structs and table entry types.
// Has no dependencies; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package hkt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int KEY_W       = 16;
   localparam int USED_W      = 5;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   typedef struct packed {
      logic [KEY_W-1:0] key_code;
      logic             is_press;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic [USED_W-1:0] used_entries;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] code;
      logic             held;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        entry;
   } wr_type;

endpackage

`default_nettype wire

// ===== rtl/core/hkt_table.sv =====
// Entry memory of the held key table: one write port, one registered read port.
// Depends on hkt_pkg for the entry and write request types.
`timescale 1ns / 1ps
`default_nettype none

module hkt_table
   import hkt_pkg::*;
(
   input  wire logic             clock,
   input  wire wr_type           wr,
   input  wire logic [IDX_W-1:0] rd_addr,
   output entry_type             rd_data
);

   entry_type entries_ff [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entries_ff[wr.addr] <= wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= entries_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/held_key_table_core.sv =====
// Top level of the held key table: sequencer, entry compare unit and used count.
// Depends on hkt_pkg and instantiates hkt_table.
`timescale 1ns / 1ps
`default_nettype none

// A transaction is taken when start is high and busy is low. The block then
// walks the used entries one per cycle through the single read port of the
// entry memory, updates at most one entry, and presents the result on rsp_data
// with rsp_valid high for exactly one cycle; the receiver must take it then.
// Busy is high from the cycle after acceptance through the result cycle, and the
// scan ends early at the first matching entry.
module held_key_table_core
   import hkt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EMPTY = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] chk_ff, chk_in;
   logic [KEY_W-1:0] code_ff, code_in;
   logic             press_ff, press_in;
   logic             acc_ff, acc_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             seen_ff, seen_in;
   logic [IDX_W-1:0] last_held_ff, last_held_in;

   wr_type           wr;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   logic             hit;
   logic             scan_last;

   hkt_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign hit       = (rd_data.code == code_ff);
   assign scan_last = ((CNT_W'(chk_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      chk_in        = chk_ff;
      code_in       = code_ff;
      press_in      = press_ff;
      acc_in        = acc_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      seen_in       = seen_ff;
      last_held_in  = last_held_ff;
      wr            = '0;
      rd_addr       = chk_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (start) begin
               code_in       = req_data.key_code;
               press_in      = req_data.is_press;
               chk_in        = '0;
               acc_in        = 1'b1;
               free_found_in = 1'b0;
               seen_in       = 1'b0;
               state_in      = (count_ff == '0) ? ST_EMPTY : ST_SCAN;
            end
         end
         ST_EMPTY: begin
            if (press_ff) begin
               wr.en         = 1'b1;
               wr.addr       = '0;
               wr.entry.code = code_ff;
               wr.entry.held = 1'b1;
               count_in      = CNT_W'(1);
            end
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            rd_addr = scan_last ? chk_ff : chk_ff + IDX_W'(1);
            chk_in  = rd_addr;
            if (press_ff) begin
               if (hit) begin
                  wr.en         = 1'b1;
                  wr.addr       = chk_ff;
                  wr.entry.code = code_ff;
                  wr.entry.held = 1'b1;
                  state_in      = ST_RESP;
               end else begin
                  if (!rd_data.held && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = chk_ff;
                  end
                  if (scan_last) begin
                     state_in = ST_RESP;
                     priority if (free_found_in) begin
                        wr.en         = 1'b1;
                        wr.addr       = free_idx_in;
                        wr.entry.code = code_ff;
                        wr.entry.held = 1'b1;
                     end else if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                        wr.en         = 1'b1;
                        wr.addr       = IDX_W'(count_ff);
                        wr.entry.code = code_ff;
                        wr.entry.held = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                     end else begin
                        acc_in = 1'b0;
                     end
                  end
               end
            end else begin
               if (hit) begin
                  wr.en         = 1'b1;
                  wr.addr       = chk_ff;
                  wr.entry.code = code_ff;
                  wr.entry.held = 1'b0;
                  if (scan_last) begin
                     count_in = seen_ff ? CNT_W'(last_held_ff) + CNT_W'(1) : '0;
                  end
                  state_in = ST_RESP;
               end else begin
                  if (rd_data.held) begin
                     seen_in      = 1'b1;
                     last_held_in = chk_ff;
                  end
                  if (scan_last) begin
                     state_in = ST_RESP;
                  end
               end
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff        <= chk_in;
      code_ff       <= code_in;
      press_ff      <= press_in;
      acc_ff        <= acc_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      seen_ff       <= seen_in;
      last_held_ff  <= last_held_in;
   end

   assign busy                  = (state_ff != ST_IDLE);
   assign rsp_valid             = (state_ff == ST_RESP);
   assign rsp_data.accepted     = acc_ff;
   assign rsp_data.used_entries = USED_W'(count_ff);

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("Used count exceeds the table depth.");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Accepted transaction did not raise busy.");

   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("Result strobe longer than one cycle or busy stuck.");

   a_write_busy : assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == ST_SCAN || state_ff == ST_EMPTY))
      else $error("Table write outside of a transaction.");

   a_reject_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |-> count_ff == CNT_W'(TABLE_DEPTH))
      else $error("Press rejected while the table had room.");

endmodule

`default_nettype wire

// ===== tb/held_key_table_checker.sv =====
// Checker for the held key table: watches the request and response channels,
// predicts each response from its own copy of the table, and counts mismatches.
// Depends on hkt_pkg for the payload structs and table sizes.
`timescale 1ns / 1ps

module held_key_table_checker
   import hkt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           outstanding
);

   logic [KEY_W-1:0] slot_code [TABLE_DEPTH];
   logic             slot_held [TABLE_DEPTH];
   int               used_slots;
   rsp_type          expected_rsp_q [$];

   function automatic rsp_type apply_key_event(input req_type ev);
      rsp_type r;
      int      n;
      int      i;
      int      hit;
      int      free_slot;
      int      last_held;
      r.accepted = 1'b1;
      n = used_slots;
      hit = -1;
      free_slot = -1;
      last_held = -1;
      for (i = 0; i < n && hit < 0; i++) begin
         if (slot_code[i] == ev.key_code) begin
            hit = i;
         end else if (slot_held[i]) begin
            last_held = i;
         end
      end
      if (!ev.is_press) begin
         if (hit >= 0) begin
            slot_held[hit] = 1'b0;
            if (hit == n - 1) used_slots = last_held + 1;
         end
      end else if (hit >= 0) begin
         slot_held[hit] = 1'b1;
      end else begin
         for (i = 0; i < n && free_slot < 0; i++) begin
            if (!slot_held[i]) free_slot = i;
         end
         if (free_slot >= 0) begin
            slot_code[free_slot] = ev.key_code;
            slot_held[free_slot] = 1'b1;
         end else if (n >= TABLE_DEPTH) begin
            r.accepted = 1'b0;
         end else begin
            slot_code[n] = ev.key_code;
            slot_held[n] = 1'b1;
            used_slots = n + 1;
         end
      end
      r.used_entries = USED_W'(used_slots);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         fail_count = 0;
         used_slots = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response, expected none, actual accepted=%0b used=%0d",
                        $time, rsp_data.accepted, rsp_data.used_entries);
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               if (rsp_data.accepted !== exp_rsp.accepted) begin
                  fail_count++;
                  $display("%0t: accepted mismatch, expected %0b, actual %0b",
                           $time, exp_rsp.accepted, rsp_data.accepted);
               end
               if (rsp_data.used_entries !== exp_rsp.used_entries) begin
                  fail_count++;
                  $display("%0t: used_entries mismatch, expected %0d, actual %0d",
                           $time, exp_rsp.used_entries, rsp_data.used_entries);
               end
            end
         end
         if (start && busy === 1'b0) begin
            expected_rsp_q.push_back(apply_key_event(req_data));
         end
      end
      outstanding = expected_rsp_q.size();
   end

endmodule

// ===== tb/tb_held_key_table_core.sv =====
// Testbench top for held_key_table_core: clock, reset, directed and random key
// events with bursty timing, and the final verdict from the checker's count.
// Depends on hkt_pkg, held_key_table_core and held_key_table_checker.
`timescale 1ns / 1ps

module tb_held_key_table_core;
   import hkt_pkg::*;

   localparam logic KEY_PRESS   = 1'b1;
   localparam logic KEY_RELEASE = 1'b0;
   localparam int   RANDOM_EVENTS = 1800;
   localparam int   POOL_MAX = 24;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      outstanding;

   int               burst_left;
   logic [KEY_W-1:0] key_pool [POOL_MAX];
   int               pool_size;

   held_key_table_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   held_key_table_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Called at a falling edge; returns at the falling edge after the
   // transaction was taken.
   task automatic send_key_event(input logic [KEY_W-1:0] code, input logic press);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
         repeat (gap) begin
            start = 1'b0;
            req_data = req_type'($urandom);
            @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      start = 1'b1;
      req_data.key_code = code;
      req_data.is_press = press;
      while (busy !== 1'b0) @(negedge clock);
      @(negedge clock);
   endtask

   initial begin
      int i;
      int phase_len;
      int press_pct;
      int sent;
      logic [KEY_W-1:0] code;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      burst_left = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_key_event(16'h0000, KEY_PRESS);
      send_key_event(16'hFFFF, KEY_PRESS);
      send_key_event(16'h1234, KEY_RELEASE);
      send_key_event(16'h0000, KEY_RELEASE);
      send_key_event(16'hFFFF, KEY_RELEASE);
      for (i = 0; i < TABLE_DEPTH; i++) send_key_event(KEY_W'(16'h0100 + i), KEY_PRESS);
      send_key_event(16'h8001, KEY_PRESS);
      send_key_event(16'h0105, KEY_RELEASE);
      send_key_event(16'h8001, KEY_PRESS);
      send_key_event(16'h0103, KEY_PRESS);
      send_key_event(KEY_W'(16'h0100 + TABLE_DEPTH - 1), KEY_RELEASE);

      sent = 0;
      while (sent < RANDOM_EVENTS) begin
         case ($urandom_range(0, 2))
            0: press_pct = 30;
            1: press_pct = 50;
            default: press_pct = 80;
         endcase
         pool_size = $urandom_range(4, POOL_MAX);
         for (i = 0; i < pool_size; i++) key_pool[i] = KEY_W'($urandom);
         phase_len = $urandom_range(60, 200);
         if (phase_len > RANDOM_EVENTS - sent) phase_len = RANDOM_EVENTS - sent;
         repeat (phase_len) begin
            if ($urandom_range(0, 9) == 0) code = KEY_W'($urandom);
            else code = key_pool[$urandom_range(0, pool_size - 1)];
            send_key_event(code, ($urandom_range(1, 100) <= press_pct) ? KEY_PRESS : KEY_RELEASE);
            sent++;
         end
      end

      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (TABLE_DEPTH + 8) @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/hkt_pkg.sv
rtl/core/hkt_table.sv
rtl/core/held_key_table_core.sv
tb/held_key_table_checker.sv
tb/tb_held_key_table_core.sv
